@@ rtl/core/ppu_pkg.sv @@
// Shared types, constants and lookup tables for the particle pool update block.
package ppu_pkg;

    localparam int POOL_SIZE = 512;
    localparam int IDX_W     = 9;
    localparam int CNT_W     = 10;
    localparam int ADDR_W    = 3;
    localparam int CODE_N    = 128;

    localparam logic [1:0] MODE_SPAWN = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [ADDR_W-1:0] REG_POOL_IN_USE = 3'd0;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic        [1:0]  mode;
        logic        [15:0] delta_time;
        logic signed [31:0] object_x;
        logic signed [31:0] object_y;
        logic signed [31:0] object_vx;
        logic signed [31:0] object_vy;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic        [6:0]  jitter_code;
        logic        [6:0]  bright_code;
        logic        [8:0]  entry_index;
    } req_item_t;

    typedef struct packed {
        logic        [8:0]  slot;
        logic               alive;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [16:0] brightness;
        logic        [16:0] alpha;
        logic        [9:0]  live_count;
    } rsp_item_t;

    typedef struct packed {
        logic        [16:0] life;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic        [16:0] br;
        logic        [16:0] al;
    } rec_t;

    typedef logic signed [19:0] jit_tbl_t [CODE_N];
    typedef logic [16:0] br_tbl_t [CODE_N];

    function automatic jit_tbl_t build_jit();
        jit_tbl_t t;
        int num;
        for (int c = 0; c < CODE_N; c++) begin
            num = (c - 50) * 65536;
            if (num < 0) begin
                t[c] = 20'(-((-num + 5) / 10));
            end
            else begin
                t[c] = 20'((num + 5) / 10);
            end
        end
        return t;
    endfunction

    function automatic br_tbl_t build_br();
        br_tbl_t t;
        for (int c = 0; c < CODE_N; c++) begin
            t[c] = 17'(32768 + (c * 65536 + 50) / 100);
        end
        return t;
    endfunction

    localparam jit_tbl_t JIT_TBL = build_jit();
    localparam br_tbl_t  BR_TBL  = build_br();

    function automatic logic signed [31:0] sat32(logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/particle_pool_update.sv @@
// Top level of the particle pool update block: pool memory, sequencer and APB register.
//
// The block keeps a pool of particle records in one synchronous memory and
// serves one transaction on the req channel at a time; each yields exactly
// one transaction on the rsp channel (valid/ready on both sides).
// The single APB register pool_in_use (address 0) sets how many slots are
// active; writing it starts a recount of the live slots, during which
// req_ready stays low.
// Steps per transaction:
//   spawn: a reciprocal multiplication for the velocity divide by ten,
//          then a next-fit search that reads the memory slot by slot, a
//          write step and a result step.
//   tick:  one slot per cycle through a three-stage
//          read-modify-write pipeline on the memory port.
//   read:  a memory read, then a result step.  No-operation: the result step alone.
// The memory's single read port makes the search and the tick go slot by slot.
// After reset the block clears every memory slot before it
// raises req_ready. A finished result waits in the output register while
// rsp_ready is low; the block then holds before loading the next result.
module particle_pool_update (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ppu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  ppu_pkg::req_item_t        req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output ppu_pkg::rsp_item_t        rsp
);
    import ppu_pkg::*;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_SEARCH = 4'd3;
    localparam logic [3:0] ST_SPWR   = 4'd4;
    localparam logic [3:0] ST_TICK   = 4'd5;
    localparam logic [3:0] ST_READ   = 4'd6;
    localparam logic [3:0] ST_RDWAIT = 4'd7;
    localparam logic [3:0] ST_COUNT  = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

    rec_t rec_mem [POOL_SIZE];
    rec_t mem_rd_reg;
    logic mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [IDX_W-1:0] mem_ra;
    rec_t mem_wd;

    logic [3:0] state_reg;
    logic [CNT_W-1:0] pool_reg;
    logic recount_reg;
    logic [CNT_W-1:0] live_reg;
    logic [IDX_W-1:0] last_reg;
    req_item_t in_reg;
    rsp_item_t res_reg;
    rsp_item_t out_reg;
    logic out_valid_reg;
    logic [IDX_W-1:0] clr_reg;

    logic [31:0] dx_a_reg, dy_a_reg, dx_q_reg, dy_q_reg;
    logic dx_neg_reg, dy_neg_reg;
    logic [63:0] dx_prod, dy_prod;

    logic [CNT_W-1:0] sidx_reg;
    logic sphase_reg;
    logic sfound_reg;
    logic [IDX_W-1:0] fslot_reg;

    logic t1_v_reg, t2_v_reg;
    logic [IDX_W-1:0] t1_a_reg, t2_a_reg;
    rec_t t2_rec_reg;
    logic t2_alive_reg;
    logic signed [48:0] t2_px_reg, t2_py_reg;
    logic [CNT_W-1:0] acc_reg;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] lim;
    logic cfg_wr;
    logic req_fire;
    logic out_free;
    logic [16:0] life_dec;
    logic signed [48:0] prod_x, prod_y;
    logic [17:0] fade;
    rec_t tick_wd;
    rec_t spawn_wd;
    logic search_issue;
    logic search_done;

    function automatic logic [31:0] mag_plus5(logic signed [31:0] v);
        logic signed [32:0] e;
        logic [32:0] m;
        e = 33'(v);
        m = v[31] ? 33'(-e) : 33'(e);
        return 32'(m + 33'd5);
    endfunction

    function automatic logic signed [31:0] apply_sign(logic neg, logic [31:0] q);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] step_pos(logic signed [31:0] p,
                                                    logic signed [48:0] prod);
        logic neg;
        logic [48:0] mag;
        logic [32:0] q;
        logic signed [33:0] st;
        neg = prod[48];
        mag = neg ? 49'(-prod) : 49'(prod);
        q = 33'((mag + 49'd32768) >> 16);
        st = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return sat32(34'(p) - st);
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr == REG_POOL_IN_USE) ? 32'(pool_reg) : 32'd0;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_POOL_IN_USE);
    assign req_ready = (state_reg == ST_IDLE) && !recount_reg;
    assign req_fire = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        if (pool_reg == '0) begin
            n_eff = CNT_W'(1);
        end
        else if (pool_reg > CNT_W'(POOL_SIZE)) begin
            n_eff = CNT_W'(POOL_SIZE);
        end
        else begin
            n_eff = pool_reg;
        end
        lim = ({1'b0, last_reg} < n_eff) ? {1'b0, last_reg} : n_eff;
    end

    always_comb
    begin
        dx_prod = 64'(dx_a_reg) * 64'(DIV10_RECIP);
        dy_prod = 64'(dy_a_reg) * 64'(DIV10_RECIP);
        life_dec = (mem_rd_reg.life > {1'b0, in_reg.delta_time})
                 ? 17'(mem_rd_reg.life - {1'b0, in_reg.delta_time}) : 17'd0;
        prod_x = mem_rd_reg.vx * $signed({1'b0, in_reg.delta_time});
        prod_y = mem_rd_reg.vy * $signed({1'b0, in_reg.delta_time});
        fade = 18'(((19'(in_reg.delta_time) << 2) + 19'(in_reg.delta_time) + 19'd1) >> 1);
        tick_wd = t2_rec_reg;
        if (t2_alive_reg) begin
            tick_wd.px = step_pos(t2_rec_reg.px, t2_px_reg);
            tick_wd.py = step_pos(t2_rec_reg.py, t2_py_reg);
            tick_wd.al = ({1'b0, t2_rec_reg.al} > fade)
                       ? 17'({1'b0, t2_rec_reg.al} - fade) : 17'd0;
        end
        spawn_wd.life = ONE_Q16;
        spawn_wd.px = sat32(34'(in_reg.object_x) + 34'(JIT_TBL[in_reg.jitter_code])
                            + 34'(in_reg.offset_x));
        spawn_wd.py = sat32(34'(in_reg.object_y) + 34'(JIT_TBL[in_reg.jitter_code])
                            + 34'(in_reg.offset_y));
        spawn_wd.vx = apply_sign(dx_neg_reg, dx_q_reg);
        spawn_wd.vy = apply_sign(dy_neg_reg, dy_q_reg);
        spawn_wd.br = BR_TBL[in_reg.bright_code];
        spawn_wd.al = ONE_Q16;
    end

    always_comb
    begin
        search_issue = (!sphase_reg && sidx_reg < n_eff) || (sphase_reg && sidx_reg < lim);
        search_done = sphase_reg && !(sidx_reg < lim) && !t1_v_reg;
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
            end
            ST_SEARCH, ST_TICK, ST_COUNT:
            begin
                mem_ra = sidx_reg[IDX_W-1:0];
                if (state_reg == ST_TICK) begin
                    mem_we = t2_v_reg;
                    mem_wa = t2_a_reg;
                    mem_wd = tick_wd;
                end
            end
            ST_SPWR:
            begin
                mem_we = 1'b1;
                mem_wa = fslot_reg;
                mem_wd = spawn_wd;
            end
            ST_READ:
            begin
                mem_ra = in_reg.entry_index;
            end
            default:
            begin
                mem_ra = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            rec_mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= rec_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            pool_reg <= CNT_W'(POOL_SIZE);
            recount_reg <= 1'b0;
            live_reg <= '0;
            last_reg <= '0;
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
            sidx_reg <= '0;
            sphase_reg <= 1'b0;
            sfound_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            acc_reg <= '0;
        end
        else begin
            if (cfg_wr) begin
                pool_reg <= pwdata[CNT_W-1:0];
            end
            if (cfg_wr) begin
                recount_reg <= 1'b1;
            end
            else if ((state_reg == ST_COUNT) && !(sidx_reg < n_eff) && !t1_v_reg) begin
                recount_reg <= 1'b0;
            end
            if ((state_reg == ST_FIN) && out_free) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(POOL_SIZE - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    sidx_reg <= '0;
                    t1_v_reg <= 1'b0;
                    t2_v_reg <= 1'b0;
                    acc_reg <= '0;
                    if (recount_reg) begin
                        state_reg <= ST_COUNT;
                    end
                    else if (req_fire) begin
                        in_reg <= req;
                        res_reg <= '{slot: '0, alive: 1'b0, pos_x: '0, pos_y: '0,
                                     brightness: '0, alpha: '0, live_count: live_reg};
                        unique case (req.mode)
                            MODE_SPAWN:
                            begin
                                dx_a_reg <= mag_plus5(req.object_vx);
                                dy_a_reg <= mag_plus5(req.object_vy);
                                dx_neg_reg <= req.object_vx[31];
                                dy_neg_reg <= req.object_vy[31];
                                state_reg <= ST_DIV;
                            end
                            MODE_TICK: state_reg <= ST_TICK;
                            MODE_READ: state_reg <= ST_READ;
                            MODE_NOP:  state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_DIV:
                begin
                    dx_q_reg <= 32'(dx_prod[63:35]);
                    dy_q_reg <= 32'(dy_prod[63:35]);
                    sidx_reg <= {1'b0, last_reg};
                    sphase_reg <= 1'b0;
                    t1_v_reg <= 1'b0;
                    state_reg <= ST_SEARCH;
                end
                ST_SEARCH:
                begin
                    if (t1_v_reg && mem_rd_reg.life == '0) begin
                        fslot_reg <= t1_a_reg;
                        sfound_reg <= 1'b1;
                        state_reg <= ST_SPWR;
                    end
                    else if (search_done) begin
                        fslot_reg <= '0;
                        sfound_reg <= 1'b0;
                        state_reg <= ST_SPWR;
                    end
                    else if (!sphase_reg && !(sidx_reg < n_eff)) begin
                        sphase_reg <= 1'b1;
                        sidx_reg <= '0;
                        t1_v_reg <= 1'b0;
                    end
                    else begin
                        t1_v_reg <= search_issue;
                        t1_a_reg <= sidx_reg[IDX_W-1:0];
                        if (search_issue) begin
                            sidx_reg <= sidx_reg + CNT_W'(1);
                        end
                    end
                end
                ST_SPWR:
                begin
                    last_reg <= fslot_reg;
                    live_reg <= live_reg + CNT_W'(sfound_reg);
                    res_reg <= '{slot: fslot_reg, alive: 1'b1, pos_x: spawn_wd.px,
                                 pos_y: spawn_wd.py, brightness: spawn_wd.br,
                                 alpha: spawn_wd.al,
                                 live_count: live_reg + CNT_W'(sfound_reg)};
                    state_reg <= ST_FIN;
                end
                ST_TICK:
                begin
                    t1_v_reg <= sidx_reg < n_eff;
                    t1_a_reg <= sidx_reg[IDX_W-1:0];
                    if (sidx_reg < n_eff) begin
                        sidx_reg <= sidx_reg + CNT_W'(1);
                    end
                    t2_v_reg <= t1_v_reg;
                    t2_a_reg <= t1_a_reg;
                    t2_rec_reg <= '{life: life_dec, px: mem_rd_reg.px, py: mem_rd_reg.py,
                                    vx: mem_rd_reg.vx, vy: mem_rd_reg.vy,
                                    br: mem_rd_reg.br, al: mem_rd_reg.al};
                    t2_alive_reg <= life_dec != '0;
                    t2_px_reg <= prod_x;
                    t2_py_reg <= prod_y;
                    if (t2_v_reg && t2_alive_reg) begin
                        acc_reg <= acc_reg + CNT_W'(1);
                    end
                    if (!(sidx_reg < n_eff) && !t1_v_reg && !t2_v_reg) begin
                        live_reg <= acc_reg;
                        res_reg.live_count <= acc_reg;
                        state_reg <= ST_FIN;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_RDWAIT;
                end
                ST_RDWAIT:
                begin
                    res_reg <= '{slot: in_reg.entry_index, alive: mem_rd_reg.life != '0,
                                 pos_x: mem_rd_reg.px, pos_y: mem_rd_reg.py,
                                 brightness: mem_rd_reg.br, alpha: mem_rd_reg.al,
                                 live_count: res_reg.live_count};
                    state_reg <= ST_FIN;
                end
                ST_COUNT:
                begin
                    t1_v_reg <= sidx_reg < n_eff;
                    if (sidx_reg < n_eff) begin
                        sidx_reg <= sidx_reg + CNT_W'(1);
                    end
                    if (t1_v_reg && mem_rd_reg.life != '0) begin
                        acc_reg <= acc_reg + CNT_W'(1);
                    end
                    if (!(sidx_reg < n_eff) && !t1_v_reg) begin
                        live_reg <= acc_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FIN:
                begin
                    if (out_free) begin
                        out_reg <= res_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(POOL_SIZE))
        else $error("live count exceeds pool size");

    a_spawn_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPWR) |-> ({1'b0, fslot_reg} < n_eff))
        else $error("spawn slot outside active pool");

    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && $past(state_reg == ST_IDLE) |-> !t1_v_reg && !t2_v_reg)
        else $error("pipeline busy while idle");

    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE) && (state_reg != ST_CLEAR))
        else $error("accepted transaction not started");

endmodule

@@ sim/particle_pool_update_tb.sv @@
// Testbench for particle_pool_update: directed table and random traffic checked by a predictor.
`timescale 1ns / 1ps

module particle_pool_update_tb;
    import ppu_pkg::*;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic req_valid;
    logic req_ready;
    req_item_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_item_t rsp;

    particle_pool_update i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    typedef struct {
        req_item_t item;
        logic has_exp;
        rsp_item_t exp_rsp;
    } stim_row_t;

    logic [16:0] pm_life [POOL_SIZE];
    logic signed [31:0] pm_px [POOL_SIZE];
    logic signed [31:0] pm_py [POOL_SIZE];
    logic signed [31:0] pm_vx [POOL_SIZE];
    logic signed [31:0] pm_vy [POOL_SIZE];
    logic [16:0] pm_br [POOL_SIZE];
    logic [16:0] pm_al [POOL_SIZE];
    int unsigned pm_last;
    int unsigned pm_in_use;

    rsp_item_t pending_rsp[$];
    int mismatches;
    int stall_left;
    logic timed_out;
    logic quiet;
    logic rsp_burst_en;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint round_div(longint num, longint den);
        if (num < 0)
        begin
            return -((-num + den / 2) / den);
        end
        return (num + den / 2) / den;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic rsp_item_t pool_predict(req_item_t it);
        rsp_item_t r;
        int unsigned n;
        int unsigned s;
        int unsigned lim;
        int unsigned cnt;
        logic found;
        logic report;
        longint jit;
        int unsigned fade;
        n = pm_in_use;
        if (n < 1) n = 1;
        if (n > POOL_SIZE) n = POOL_SIZE;
        s = 0;
        report = 1'b0;
        if (it.mode == MODE_SPAWN)
        begin
            found = 1'b0;
            lim = (pm_last < n) ? pm_last : n;
            for (int i = pm_last; i < n && !found; i++)
            begin
                if (pm_life[i] == 0)
                begin
                    s = i;
                    found = 1'b1;
                end
            end
            for (int i = 0; i < lim && !found; i++)
            begin
                if (pm_life[i] == 0)
                begin
                    s = i;
                    found = 1'b1;
                end
            end
            if (!found) s = 0;
            pm_last = s;
            jit = round_div((longint'(it.jitter_code) - 50) * 65536, 10);
            pm_px[s] = clip32(longint'(it.object_x) + jit + longint'(it.offset_x));
            pm_py[s] = clip32(longint'(it.object_y) + jit + longint'(it.offset_y));
            pm_vx[s] = 32'(round_div(longint'(it.object_vx), 10));
            pm_vy[s] = 32'(round_div(longint'(it.object_vy), 10));
            pm_br[s] = 17'(32768 + round_div(longint'(it.bright_code) * 65536, 100));
            pm_al[s] = 17'd65536;
            pm_life[s] = 17'd65536;
            report = 1'b1;
        end
        else if (it.mode == MODE_TICK)
        begin
            fade = (int'(it.delta_time) * 5 + 1) >> 1;
            for (int i = 0; i < n; i++)
            begin
                pm_life[i] = (pm_life[i] > it.delta_time) ? pm_life[i] - it.delta_time : 17'd0;
                if (pm_life[i] > 0)
                begin
                    pm_px[i] = clip32(longint'(pm_px[i])
                        - round_div(longint'(pm_vx[i]) * it.delta_time, 65536));
                    pm_py[i] = clip32(longint'(pm_py[i])
                        - round_div(longint'(pm_vy[i]) * it.delta_time, 65536));
                    pm_al[i] = (pm_al[i] > fade) ? pm_al[i] - 17'(fade) : 17'd0;
                end
            end
        end
        else if (it.mode == MODE_READ)
        begin
            s = it.entry_index;
            report = 1'b1;
        end
        cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            if (pm_life[i] > 0) cnt++;
        end
        r = '0;
        r.slot = 9'(s);
        if (report)
        begin
            r.alive = (pm_life[s] > 0);
            r.pos_x = pm_px[s];
            r.pos_y = pm_py[s];
            r.brightness = pm_br[s];
            r.alpha = pm_al[s];
        end
        r.live_count = 10'(cnt);
        return r;
    endfunction

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == REG_POOL_IN_USE) pm_in_use = data[9:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic send_item(req_item_t it, logic check_row, rsp_item_t row_rsp, logic gaps);
        rsp_item_t e;
        if (gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        e = pool_predict(it);
        if (check_row && e !== row_rsp)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("table row disagrees with predictor: %h vs %h", row_rsp, e);
            end
        end
        pending_rsp = {pending_rsp, e};
        @(negedge clk);
    endtask

    function automatic req_item_t random_item(int spawn_pct, logic wide);
        req_item_t it;
        int p;
        it.delta_time = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
        it.object_x = $urandom;
        it.object_y = $urandom;
        it.object_vx = $urandom;
        it.object_vy = $urandom;
        if (!wide)
        begin
            it.object_x = $signed(it.object_x) >>> $urandom_range(0, 24);
            it.object_y = $signed(it.object_y) >>> $urandom_range(0, 24);
        end
        it.offset_x = wide ? $urandom : $signed($urandom) >>> 20;
        it.offset_y = wide ? $urandom : $signed($urandom) >>> 20;
        it.jitter_code = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
        it.bright_code = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
        it.entry_index = ($urandom_range(0, 1) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40));
        p = $urandom_range(0, 99);
        if (p < spawn_pct) it.mode = MODE_SPAWN;
        else if (p < spawn_pct + 15) it.mode = MODE_TICK;
        else if (p < 96) it.mode = MODE_READ;
        else it.mode = MODE_NOP;
        return it;
    endfunction

    always @(posedge clk)
    begin
        rsp_item_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %h", rsp);
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.slot !== e.slot || rsp.alive !== e.alive || rsp.pos_x !== e.pos_x
                    || rsp.pos_y !== e.pos_y || rsp.brightness !== e.brightness
                    || rsp.alpha !== e.alpha || rsp.live_count !== e.live_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"mismatch: expected slot=%0d alive=%0d x=%h y=%h",
                                  " br=%0d al=%0d live=%0d"},
                            e.slot, e.alive, e.pos_x, e.pos_y, e.brightness, e.alpha,
                            e.live_count);
                        $display({"          actual   slot=%0d alive=%0d x=%h y=%h",
                                  " br=%0d al=%0d live=%0d"},
                            rsp.slot, rsp.alive, rsp.pos_x, rsp.pos_y, rsp.brightness,
                            rsp.alpha, rsp.live_count);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rsp_burst_en || quiet)
        begin
            stall_left = 0;
            rsp_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= (stall_left == 0);
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            stall_left = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        #50ms;
        timed_out = 1'b1;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        req_item_t it;
        rsp_item_t dummy;
        int sizes[5];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b1;
        mismatches = 0;
        stall_left = 0;
        timed_out = 1'b0;
        quiet = 1'b0;
        rsp_burst_en = 1'b0;
        dummy = '0;
        pm_in_use = 512;
        pm_last = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pm_life[i] = '0; pm_px[i] = '0; pm_py[i] = '0; pm_vx[i] = '0;
            pm_vy[i] = '0; pm_br[i] = '0; pm_al[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        row.item = '0; row.has_exp = 1'b0; row.exp_rsp = '0;
        row.item.mode = MODE_READ; row.item.entry_index = 9'd0;
        row.has_exp = 1'b1; rows = {rows, row};
        row.item.entry_index = 9'd511; row.exp_rsp = '0; row.exp_rsp.slot = 9'd511;
        rows = {rows, row};
        row.item.mode = MODE_NOP; row.exp_rsp = '0; rows = {rows, row};
        row.item.mode = MODE_TICK; row.item.delta_time = 16'hFFFF; rows = {rows, row};
        row = '{item: '0, has_exp: 1'b0, exp_rsp: '0};
        row.item.mode = MODE_SPAWN; row.item.jitter_code = 7'd50; row.item.bright_code = 7'd0;
        row.has_exp = 1'b1;
        row.exp_rsp = '{slot: 9'd0, alive: 1'b1, pos_x: 32'sd0, pos_y: 32'sd0,
                        brightness: 17'd32768, alpha: 17'd65536, live_count: 10'd1};
        rows = {rows, row};
        row.has_exp = 1'b0;
        row.item.object_x = 32'sh7FFF_FFFF; row.item.object_y = 32'sh8000_0000;
        row.item.offset_x = 32'sh7FFF_FFFF; row.item.offset_y = 32'sh8000_0000;
        row.item.object_vx = 32'sh7FFF_FFFF; row.item.object_vy = 32'sh8000_0000;
        row.item.jitter_code = 7'd127; row.item.bright_code = 7'd127; rows = {rows, row};
        row.item.object_x = 32'sh8000_0000; row.item.object_y = 32'sh7FFF_FFFF;
        row.item.offset_x = 32'sh8000_0000; row.item.offset_y = 32'sh7FFF_FFFF;
        row.item.object_vx = 32'sh8000_0000; row.item.object_vy = 32'sh7FFF_FFFF;
        row.item.jitter_code = 7'd0; row.item.bright_code = 7'd99; rows = {rows, row};
        row.item.object_vx = -32'sd15; row.item.object_vy = 32'sd25; row.item.jitter_code = 7'd99;
        rows = {rows, row};
        row.item = '0; row.item.mode = MODE_TICK; row.item.delta_time = 16'd1;
        rows = {rows, row};
        row.item.delta_time = 16'd32768; rows = {rows, row};
        for (int i = 0; i < 4; i++)
        begin
            row.item.mode = MODE_READ; row.item.entry_index = 9'(i); rows = {rows, row};
        end
        row.item.mode = MODE_TICK; row.item.delta_time = 16'hFFFF; rows = {rows, row};
        row.item.mode = MODE_READ; row.item.entry_index = 9'd1; rows = {rows, row};

        foreach (rows[k])
        begin
            send_item(rows[k].item, rows[k].has_exp, rows[k].exp_rsp, 1'b0);
        end
        drain_results();

        rsp_burst_en = 1'b1;
        sizes = '{1, 3, 0, 512, 37};
        foreach (sizes[p])
        begin
            apb_write(REG_POOL_IN_USE, 32'(sizes[p]));
            for (int k = 0; k < ((sizes[p] == 512) ? 100 : 150); k++)
            begin
                it = random_item((k % 40 < 25) ? 70 : 10, ($urandom_range(0, 4) == 0));
                send_item(it, 1'b0, dummy, 1'b1);
            end
            drain_results();
        end
        apb_write(REG_POOL_IN_USE, 32'd8);
        for (int k = 0; k < 200; k++)
        begin
            if (k >= 150) quiet = 1'b1;
            it = random_item(40, 1'b0);
            send_item(it, 1'b0, dummy, 1'b1);
        end
        req_valid <= 1'b0;
        quiet = 1'b1;

        @(negedge clk);
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        if (mismatches == 0 && !timed_out)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
